### src/rme_pkg.sv
// Shared types and constants of the RSA modular exponentiation block.
// Depends on nothing; used by the controller, the datapath and the top level.
package rme_pkg;

  localparam int WORD_BITS = 32;
  localparam int PROD_BITS = 2 * WORD_BITS;
  localparam int RED_CNT_W = $clog2(WORD_BITS);
  localparam int ADDR_BITS = 4;

  // Register indexes (byte address divided by four).
  localparam logic [1:0] REG_MODULUS     = 2'd0;
  localparam logic [1:0] REG_PUBLIC_EXP  = 2'd1;
  localparam logic [1:0] REG_PRIVATE_EXP = 2'd2;

  // Operation codes of an input beat.
  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  typedef enum logic [1:0] {
    RS_ACC  = 2'd0,
    RS_ONE  = 2'd1,
    RS_ZERO = 2'd2
  } res_sel_t;

  typedef struct packed {
    logic     load;       // latch message, exponent and acc = 1
    logic     mul;        // form a product and clear the reducer
    logic     mul_acc;    // product is acc * base, else base * base
    logic     red;        // one two-bit reduction step
    logic     wb_acc;     // write remainder to the accumulator
    logic     wb_base;    // write remainder to the base
    logic     shift_exp;  // move to the next exponent bit
    logic     out_load;   // capture the result register
    res_sel_t res_sel;
  } rme_cmd_t;

  typedef struct packed {
    logic sel_exp_zero;   // exponent chosen by the waiting beat is zero
    logic mod_zero;
    logic exp_bit;
    logic exp_zero;
    logic exp_upper_zero;
    logic red_last;
  } rme_sts_t;

endpackage

### src/rme_datapath.sv
// Datapath of the modular exponentiation block: operand registers, one
// 32x32 multiplier and a two-bit-per-cycle shift-subtract reducer.
// Depends on rme_pkg.
module rme_datapath (
  input  logic                             clk,
  input  rme_pkg::rme_cmd_t                cmd,
  output rme_pkg::rme_sts_t                sts,
  input  logic                             in_operation,
  input  logic [rme_pkg::WORD_BITS-1:0]    in_message_value,
  input  logic [rme_pkg::WORD_BITS-1:0]    modulus,
  input  logic [rme_pkg::WORD_BITS-1:0]    public_exponent,
  input  logic [rme_pkg::WORD_BITS-1:0]    private_exponent,
  output logic [rme_pkg::WORD_BITS-1:0]    result_value
);
  import rme_pkg::*;

  logic [WORD_BITS-1:0] acc_r, acc_nxt;
  logic [WORD_BITS-1:0] base_r, base_nxt;
  logic [WORD_BITS-1:0] exp_r, exp_nxt;
  logic [PROD_BITS-1:0] prod_r, prod_nxt;
  logic [WORD_BITS-1:0] rem_r, rem_nxt;
  logic [RED_CNT_W-1:0] red_cnt_r, red_cnt_nxt;
  logic [WORD_BITS-1:0] res_r, res_nxt;
  logic [WORD_BITS-1:0] sel_exp;
  logic [WORD_BITS-1:0] mul_a;
  logic [WORD_BITS:0]   t1, t2;
  logic [WORD_BITS-1:0] r1;

  assign sel_exp = (in_operation == OP_DECRYPT) ? private_exponent : public_exponent;
  assign mul_a   = cmd.mul_acc ? acc_r : base_r;

  // Two restoring steps: the partial remainder always stays below the modulus.
  always_comb begin
    t1 = {rem_r, prod_r[PROD_BITS-1]};
    if (t1 >= {1'b0, modulus}) begin
      t1 = t1 - {1'b0, modulus};
    end
    r1 = t1[WORD_BITS-1:0];
    t2 = {r1, prod_r[PROD_BITS-2]};
    if (t2 >= {1'b0, modulus}) begin
      t2 = t2 - {1'b0, modulus};
    end
  end

  always_comb begin
    acc_nxt     = acc_r;
    base_nxt    = base_r;
    exp_nxt     = exp_r;
    prod_nxt    = prod_r;
    rem_nxt     = rem_r;
    red_cnt_nxt = red_cnt_r;
    res_nxt     = res_r;
    if (cmd.load) begin
      acc_nxt  = WORD_BITS'(1);
      base_nxt = in_message_value;
      exp_nxt  = sel_exp;
    end
    if (cmd.mul) begin
      prod_nxt    = PROD_BITS'(mul_a) * PROD_BITS'(base_r);
      rem_nxt     = '0;
      red_cnt_nxt = '0;
    end
    if (cmd.red) begin
      prod_nxt    = {prod_r[PROD_BITS-3:0], 2'b00};
      rem_nxt     = t2[WORD_BITS-1:0];
      red_cnt_nxt = red_cnt_r + RED_CNT_W'(1);
    end
    if (cmd.wb_acc) begin
      acc_nxt = rem_r;
    end
    if (cmd.wb_base) begin
      base_nxt = rem_r;
    end
    if (cmd.shift_exp) begin
      exp_nxt = {1'b0, exp_r[WORD_BITS-1:1]};
    end
    if (cmd.out_load) begin
      case (cmd.res_sel)
        RS_ONE:  res_nxt = WORD_BITS'(1);
        RS_ZERO: res_nxt = '0;
        default: res_nxt = acc_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    acc_r     <= acc_nxt;
    base_r    <= base_nxt;
    exp_r     <= exp_nxt;
    prod_r    <= prod_nxt;
    rem_r     <= rem_nxt;
    red_cnt_r <= red_cnt_nxt;
    res_r     <= res_nxt;
  end

  assign sts.sel_exp_zero   = (sel_exp == '0);
  assign sts.mod_zero       = (modulus == '0);
  assign sts.exp_bit        = exp_r[0];
  assign sts.exp_zero       = (exp_r == '0);
  assign sts.exp_upper_zero = (exp_r[WORD_BITS-1:1] == '0);
  assign sts.red_last       = (red_cnt_r == RED_CNT_W'(WORD_BITS - 1));
  assign result_value       = res_r;

endmodule

### src/rme_controller.sv
// Controller state machine of the modular exponentiation block: sequences
// the multiply and reduce steps per exponent bit and owns the handshakes.
// Depends on rme_pkg.
module rme_controller (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  rme_pkg::rme_sts_t sts,
  output rme_pkg::rme_cmd_t cmd
);
  import rme_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CHECK = 6'b000010,
    S_MUL   = 6'b000100,
    S_RED   = 6'b001000,
    S_WB    = 6'b010000,
    S_FIN   = 6'b100000
  } state_t;

  typedef enum logic {
    ST_MULT   = 1'b0,
    ST_SQUARE = 1'b1
  } step_t;

  state_t   state_r, state_nxt;
  step_t    step_r, step_nxt;
  res_sel_t res_sel_r, res_sel_nxt;
  logic     out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    res_sel_nxt   = res_sel_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    cmd.res_sel   = res_sel_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (sts.sel_exp_zero) begin
            res_sel_nxt = RS_ONE;
            state_nxt   = S_FIN;
          end else if (sts.mod_zero) begin
            res_sel_nxt = RS_ZERO;
            state_nxt   = S_FIN;
          end else begin
            res_sel_nxt = RS_ACC;
            state_nxt   = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (sts.exp_zero) begin
          state_nxt = S_FIN;
        end else begin
          step_nxt  = sts.exp_bit ? ST_MULT : ST_SQUARE;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul     = 1'b1;
        cmd.mul_acc = (step_r == ST_MULT);
        state_nxt   = S_RED;
      end
      S_RED: begin
        cmd.red = 1'b1;
        if (sts.red_last) begin
          state_nxt = S_WB;
        end
      end
      S_WB: begin
        if (step_r == ST_MULT) begin
          cmd.wb_acc = 1'b1;
          // No set bit left above this one: the accumulator is final.
          if (sts.exp_upper_zero) begin
            state_nxt = S_FIN;
          end else begin
            step_nxt  = ST_SQUARE;
            state_nxt = S_MUL;
          end
        end else begin
          cmd.wb_base   = 1'b1;
          cmd.shift_exp = 1'b1;
          state_nxt     = S_CHECK;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= ST_MULT;
      res_sel_r   <= RS_ACC;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      res_sel_r   <= res_sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### src/rsa_modular_exponentiation_top.sv
// Top level of the RSA modular exponentiation block: configuration
// registers behind an APB-style port, controller and datapath.
// Depends on rme_pkg, rme_controller and rme_datapath.
//
// Each input beat carries an operation (encrypt or decrypt) and a 32-bit
// message; the block returns one beat holding the message raised to the
// public (encrypt) or private (decrypt) exponent modulo the modulus. The
// exponent is scanned right to left. For each set bit the accumulator is
// multiplied by the base, and the base is squared while set bits remain
// above. Every modular multiplication goes through one shared unit: the
// 32x32 product, then shift-subtract reduction that retires two product
// bits per cycle, then a write-back. Each exponent bit costs a check plus
// one multiplication (bit clear) or at most two (bit set); scanning stops
// after the highest set bit. An exponent of zero returns 1 and a modulus
// of zero returns 0. One item is processed at a time; a new input beat is
// taken as soon as the previous result is in the output register, even if
// that result has not yet been taken. Registers: modulus at byte address 0
// (reset 1), public exponent at 4 and private exponent at 8 (reset 0); the
// two low address bits are not decoded, and writes at 12 to 15 are ignored
// and read back as zero. Configuration must only be written while no item
// is in progress.
module rsa_modular_exponentiation_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_operation,
  input  logic [rme_pkg::WORD_BITS-1:0]       in_message_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [rme_pkg::WORD_BITS-1:0]       out_result_value,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rme_pkg::ADDR_BITS-1:0]       paddr,
  input  logic [rme_pkg::WORD_BITS-1:0]       pwdata,
  output logic [rme_pkg::WORD_BITS-1:0]       prdata,
  output logic                                pready
);
  import rme_pkg::*;

  logic [WORD_BITS-1:0] modulus_r, modulus_nxt;
  logic [WORD_BITS-1:0] pub_exp_r, pub_exp_nxt;
  logic [WORD_BITS-1:0] priv_exp_r, priv_exp_nxt;
  logic                 wr_en;
  logic [1:0]           reg_idx;
  rme_cmd_t             cmd;
  rme_sts_t             sts;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[ADDR_BITS-1:2];

  always_comb begin
    modulus_nxt  = modulus_r;
    pub_exp_nxt  = pub_exp_r;
    priv_exp_nxt = priv_exp_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_MODULUS:     modulus_nxt  = pwdata;
        REG_PUBLIC_EXP:  pub_exp_nxt  = pwdata;
        REG_PRIVATE_EXP: priv_exp_nxt = pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MODULUS:     prdata = modulus_r;
      REG_PUBLIC_EXP:  prdata = pub_exp_r;
      REG_PRIVATE_EXP: prdata = priv_exp_r;
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r  <= WORD_BITS'(1);
      pub_exp_r  <= '0;
      priv_exp_r <= '0;
    end else begin
      modulus_r  <= modulus_nxt;
      pub_exp_r  <= pub_exp_nxt;
      priv_exp_r <= priv_exp_nxt;
    end
  end

  rme_controller u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rme_datapath u_dp (
    .clk              (clk),
    .cmd              (cmd),
    .sts              (sts),
    .in_operation     (in_operation),
    .in_message_value (in_message_value),
    .modulus          (modulus_r),
    .public_exponent  (pub_exp_r),
    .private_exponent (priv_exp_r),
    .result_value     (out_result_value)
  );

endmodule
